// File: sv/msplit_pkg.sv
`timescale 1ns / 1ps

package msplit_pkg;

   localparam int DATA_W          = 8;
   localparam int LEN_W           = 6;
   localparam int KIND_W          = 3;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int DELIM_WORDS     = 7;
   localparam int DELIM_BYTES     = 56;
   localparam int PRE_BYTES       = 2;
   localparam int HDR_END_BYTES   = 4;

   localparam logic [DATA_W-1:0] CHAR_CR = 8'd13;
   localparam logic [DATA_W-1:0] CHAR_LF = 8'd10;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_WORD_FIRST = 3'd1;

   typedef enum logic [1:0] {
      MODE_SEEK    = 2'd0,
      MODE_HEADER  = 2'd1,
      MODE_CONTENT = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER_BYTE    = 3'd0,
      KIND_HEADERS_END    = 3'd1,
      KIND_CONTENT_BYTE   = 3'd2,
      KIND_PART_END       = 3'd3,
      KIND_NOT_CONFIGURED = 3'd4
   } kind_type;

   // Compare results from the cell row, handed to the controller.
   typedef struct packed {
      logic              tail_eq;
      logic              crlf_eq;
      logic [DATA_W-1:0] release_byte;
   } cmp_type;

endpackage

// File: sv/msplit_cell.sv
`timescale 1ns / 1ps

// One byte of the holdback window. It takes its neighbor's byte on a shift
// and compares that incoming byte with the delimiter byte aligned to it.
module msplit_cell import msplit_pkg::*; (
   input  logic              clock,
   input  logic              shift_en,
   input  logic [DATA_W-1:0] byte_in,
   input  logic [DATA_W-1:0] expect_byte,
   output logic [DATA_W-1:0] byte_out,
   output logic              match
);

   logic [DATA_W-1:0] hold_ff;
   logic [DATA_W-1:0] hold_in;

   assign hold_in  = shift_en ? byte_in : hold_ff;
   assign byte_out = hold_ff;
   assign match    = (byte_in == expect_byte);

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

// File: sv/msplit_ctrl.sv
`timescale 1ns / 1ps

// Parse mode, window fill count and the result register.
module msplit_ctrl import msplit_pkg::*; #(
   parameter int MAX_DELIMITER = 56,
   parameter int WIN           = MAX_DELIMITER + 2,
   parameter int FILL_W        = $clog2(WIN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              new_message,
   input  logic [FILL_W-1:0] len_eff,
   input  cmp_type           cmp,
   output logic [FILL_W-1:0] fill_take,
   output logic              shift_en,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [DATA_W-1:0] rsp_byte
);

   mode_type          mode_ff, mode_in, mode_base;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_base;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in, kind_res;
   logic [DATA_W-1:0] byte_ff, byte_in, byte_res;
   logic              accept, len_zero, hit, tail_hit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign len_zero   = (len_eff == '0);
   assign shift_en   = accept && !len_zero;
   assign fill_base  = new_message ? '0 : fill_ff;
   assign mode_base  = new_message ? MODE_SEEK : mode_ff;
   assign fill_take  = (fill_base == FILL_W'(WIN)) ? fill_base : fill_base + 1'b1;
   assign tail_hit   = cmp.tail_eq && (fill_take >= len_eff);

   always_comb begin
      mode_in  = mode_ff;
      fill_in  = fill_ff;
      hit      = 1'b0;
      kind_res = KIND_HEADER_BYTE;
      byte_res = '0;
      if (accept) begin
         mode_in = mode_base;
         fill_in = fill_base;
         if (len_zero) begin
            hit      = 1'b1;
            kind_res = KIND_NOT_CONFIGURED;
         end else begin
            fill_in = fill_take;
            unique case (mode_base)
               MODE_HEADER: begin
                  if (fill_take >= FILL_W'(HDR_END_BYTES)) begin
                     hit = 1'b1;
                     if (cmp.crlf_eq) begin
                        fill_in  = '0;
                        mode_in  = MODE_CONTENT;
                        kind_res = KIND_HEADERS_END;
                     end else begin
                        kind_res = KIND_HEADER_BYTE;
                        byte_res = cmp.release_byte;
                        fill_in  = fill_take - 1'b1;
                     end
                  end
               end
               MODE_CONTENT: begin
                  if (tail_hit) begin
                     hit      = 1'b1;
                     fill_in  = '0;
                     mode_in  = MODE_HEADER;
                     kind_res = KIND_PART_END;
                  end else if ({1'b0, fill_take} >=
                               ({1'b0, len_eff} + (FILL_W + 1)'(PRE_BYTES))) begin
                     hit      = 1'b1;
                     kind_res = KIND_CONTENT_BYTE;
                     byte_res = cmp.release_byte;
                     fill_in  = fill_take - 1'b1;
                  end
               end
               default: begin
                  // Seek: keep only the newest delimiter-length bytes.
                  if (tail_hit) begin
                     fill_in = '0;
                     mode_in = MODE_HEADER;
                  end else if (fill_take > len_eff) begin
                     fill_in = len_eff;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      kind_in = kind_ff;
      byte_in = byte_ff;
      if (accept) begin
         rsp_valid_in = hit;
         if (hit) begin
            kind_in = kind_res;
            byte_in = byte_res;
         end
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SEEK;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_byte   = byte_ff;

endmodule

// File: sv/multipart_body_splitter_unit.sv
// A result beat is registered and offered in the cycle after the input beat that causes it.
// Throughput: one input beat per cycle while no result is stalled; the window cells shift
// and compare the whole delimiter tail in the same cycle that a beat is accepted.
// Reset (synchronous, active high) clears the parse mode to seek, the window fill,
// the delimiter registers and the result valid; window bytes are not reset.
`timescale 1ns / 1ps

module multipart_body_splitter_unit import msplit_pkg::*; #(
   parameter int MAX_DELIMITER = 56
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                   req_tuser,   // [0] new_message
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic [KIND_W-1:0]      rsp_tuser,   // [2:0] kind
   // Configuration writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // The window holds the delimiter plus the two bytes that may precede it
   // (the CR LF in front of a boundary), which are dropped on a part end.
   localparam int WIN    = MAX_DELIMITER + 2;
   localparam int FILL_W = $clog2(WIN + 1);
   localparam int IDX_W  = $clog2(WIN);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken at once.
   // ---------------------------------------------------------------------
   logic [LEN_W-1:0]      delim_length_ff, delim_length_in;
   logic [CSR_DATA_W-1:0] delim_word_ff [DELIM_WORDS];
   logic [CSR_DATA_W-1:0] delim_word_in [DELIM_WORDS];
   logic [CSR_INDEX_W-1:0] word_sel;

   assign csr_ready = 1'b1;
   assign word_sel  = csr_index - CSR_DELIM_WORD_FIRST;

   always_comb begin
      delim_length_in = delim_length_ff;
      delim_word_in   = delim_word_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DELIM_LENGTH) begin
            delim_length_in = csr_data[LEN_W-1:0];
         end else begin
            delim_word_in[word_sel] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_length_ff <= '0;
         for (int w = 0; w < DELIM_WORDS; w++) begin
            delim_word_ff[w] <= '0;
         end
      end else begin
         delim_length_ff <= delim_length_in;
         delim_word_ff   <= delim_word_in;
      end
   end

   // A length beyond MAX_DELIMITER behaves as MAX_DELIMITER, the largest length.
   logic [FILL_W-1:0] len_eff;

   always_comb begin
      if (delim_length_ff > LEN_W'(MAX_DELIMITER)) begin
         len_eff = FILL_W'(MAX_DELIMITER);
      end else begin
         len_eff = FILL_W'(delim_length_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Delimiter alignment. Cell 0 holds the newest byte, so cell k must match
   // delimiter byte (len - 1 - k). The delimiter is wired in reverse byte
   // order and shifted down by (56 - len) bytes, which puts exactly that byte
   // in front of each cell. This only moves when the configuration changes.
   // ---------------------------------------------------------------------
   logic [DELIM_BYTES*DATA_W-1:0] rev_flat;
   logic [DELIM_BYTES*DATA_W-1:0] expect_flat;
   logic [LEN_W-1:0]              shift_amt;

   for (genvar i = 0; i < DELIM_BYTES; i++) begin : g_rev
      localparam int J  = DELIM_BYTES - 1 - i;
      localparam int WI = J / 8;
      localparam int BI = J % 8;
      assign rev_flat[i*DATA_W +: DATA_W] = delim_word_ff[WI][BI*DATA_W +: DATA_W];
   end

   assign shift_amt   = LEN_W'(DELIM_BYTES) - LEN_W'(len_eff);
   assign expect_flat = rev_flat >> {shift_amt, 3'b000};

   // ---------------------------------------------------------------------
   // Row of window cells. Each accepted beat with a nonzero delimiter length
   // moves every byte one cell further from the input; the byte leaving the
   // last cell is the one the window discards on overflow.
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0] shift_byte  [WIN];
   logic [DATA_W-1:0] held_byte   [WIN];
   logic [DATA_W-1:0] expect_byte [WIN];
   logic [WIN-1:0]    cell_match;
   logic              shift_en;

   for (genvar k = 0; k < WIN; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign shift_byte[k] = req_tdata;
      end else begin : g_body
         assign shift_byte[k] = held_byte[k-1];
      end

      if (k < DELIM_BYTES) begin : g_exp
         assign expect_byte[k] = expect_flat[k*DATA_W +: DATA_W];
      end else begin : g_noexp
         assign expect_byte[k] = '0;
      end

      msplit_cell u_cell (
         .clock       (clock),
         .shift_en    (shift_en),
         .byte_in     (shift_byte[k]),
         .expect_byte (expect_byte[k]),
         .byte_out    (held_byte[k]),
         .match       (cell_match[k])
      );
   end

   // Cells past the delimiter length do not take part in the tail compare.
   logic [WIN-1:0] tail_hit;

   always_comb begin
      for (int k = 0; k < WIN; k++) begin
         tail_hit[k] = cell_match[k] || (FILL_W'(k) >= len_eff);
      end
   end

   // The oldest held byte, after the new beat has been taken, sits in cell
   // (fill - 1); that is the byte released in header and content modes.
   logic [FILL_W-1:0] fill_take;
   logic [FILL_W-1:0] release_pos;
   logic [IDX_W-1:0]  release_idx;
   cmp_type           cmp;

   assign release_pos      = fill_take - FILL_W'(1);
   assign release_idx      = release_pos[IDX_W-1:0];
   assign cmp.release_byte = shift_byte[release_idx];
   assign cmp.tail_eq      = &tail_hit;
   // Headers end when the newest four bytes read CR LF CR LF, oldest first.
   assign cmp.crlf_eq      = (shift_byte[3] == CHAR_CR) && (shift_byte[2] == CHAR_LF) &&
                             (shift_byte[1] == CHAR_CR) && (shift_byte[0] == CHAR_LF);

   // ---------------------------------------------------------------------
   // Mode sequencing and the result register. A beat is accepted whenever
   // the result register is empty or being drained in the same cycle.
   // ---------------------------------------------------------------------
   msplit_ctrl #(
      .MAX_DELIMITER (MAX_DELIMITER),
      .WIN           (WIN),
      .FILL_W        (FILL_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .new_message (req_tuser),
      .len_eff     (len_eff),
      .cmp         (cmp),
      .fill_take   (fill_take),
      .shift_en    (shift_en),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_byte    (rsp_tdata)
   );

endmodule

// File: sv/msplit_checker.sv
`timescale 1ns / 1ps

module msplit_checker import msplit_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0] rsp_tuser
);

   // The result register is empty after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // The input side only stalls while a result waits and is not taken.
   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a blocked result");

   // Marks carry no byte.
   a_mark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_HEADERS_END || rsp_tuser == KIND_PART_END ||
                     rsp_tuser == KIND_NOT_CONFIGURED) |-> rsp_tdata == '0)
      else $error("mark beat with nonzero byte");

   // An input beat is taken while a result waits only if that result leaves
   // in the same cycle.
   a_accept_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid |-> rsp_tready)
      else $error("beat accepted while a result was blocked");

endmodule

bind multipart_body_splitter_unit msplit_checker u_msplit_checker (.*);
